>>> sv/im2col_pkg.sv
`default_nettype none

package im2col_pkg;

	localparam int SRC_W   = 28;
	localparam int DST_W   = 38;
	localparam int DIM_W   = 12;
	localparam int RECIP_W = 22;
	localparam int RECIP_SHIFT = 21;

	// register map, word index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_IMAGE_HEIGHT  = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_KERNEL_HEIGHT = 3'd2,
		REG_KERNEL_WIDTH  = 3'd3,
		REG_PAD_ROWS      = 3'd4,
		REG_PAD_COLS      = 3'd5,
		REG_STRIDE_ROWS   = 3'd6,
		REG_STRIDE_COLS   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [10:0] image_height;
		logic [10:0] image_width;
		logic [4:0]  kernel_height;
		logic [4:0]  kernel_width;
		logic [3:0]  pad_rows;
		logic [3:0]  pad_cols;
		logic [4:0]  stride_rows;
		logic [4:0]  stride_cols;
	} cfg_t;

	// floor(2^21 / d); code 0 behaves as divisor 1
	localparam logic [RECIP_W-1:0] RECIP_TABLE [32] = '{
		22'd2097152, 22'd2097152, 22'd1048576, 22'd699050,
		22'd524288,  22'd419430,  22'd349525,  22'd299593,
		22'd262144,  22'd233016,  22'd209715,  22'd190650,
		22'd174762,  22'd161319,  22'd149796,  22'd139810,
		22'd131072,  22'd123361,  22'd116508,  22'd110376,
		22'd104857,  22'd99864,   22'd95325,   22'd91180,
		22'd87381,   22'd83886,   22'd80659,   22'd77672,
		22'd74898,   22'd72315,   22'd69905,   22'd67650
	};

	function automatic logic [4:0] at_least_one(input logic [4:0] v);
		return (v == 5'd0) ? 5'd1 : v;
	endfunction

	function automatic logic [RECIP_W-1:0] recip(input logic [4:0] d);
		return RECIP_TABLE[d];
	endfunction

endpackage

`default_nettype wire

>>> sv/im2col_cfg_regs.sv
`default_nettype none

module im2col_cfg_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output im2col_pkg::cfg_t        cfg
);

	im2col_pkg::cfg_t   cfg_q;
	im2col_pkg::reg_idx_t idx;
	logic               wr;

	assign idx    = im2col_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_height  <= 11'd1;
			cfg_q.image_width   <= 11'd1;
			cfg_q.kernel_height <= 5'd1;
			cfg_q.kernel_width  <= 5'd1;
			cfg_q.pad_rows      <= 4'd0;
			cfg_q.pad_cols      <= 4'd0;
			cfg_q.stride_rows   <= 5'd1;
			cfg_q.stride_cols   <= 5'd1;
		end else if (wr) begin
			unique case (idx)
				im2col_pkg::REG_IMAGE_HEIGHT:  cfg_q.image_height  <= pwdata[10:0];
				im2col_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= pwdata[10:0];
				im2col_pkg::REG_KERNEL_HEIGHT: cfg_q.kernel_height <= pwdata[4:0];
				im2col_pkg::REG_KERNEL_WIDTH:  cfg_q.kernel_width  <= pwdata[4:0];
				im2col_pkg::REG_PAD_ROWS:      cfg_q.pad_rows      <= pwdata[3:0];
				im2col_pkg::REG_PAD_COLS:      cfg_q.pad_cols      <= pwdata[3:0];
				im2col_pkg::REG_STRIDE_ROWS:   cfg_q.stride_rows   <= pwdata[4:0];
				im2col_pkg::REG_STRIDE_COLS:   cfg_q.stride_cols   <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			im2col_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(cfg_q.image_height);
			im2col_pkg::REG_IMAGE_WIDTH:   prdata = 32'(cfg_q.image_width);
			im2col_pkg::REG_KERNEL_HEIGHT: prdata = 32'(cfg_q.kernel_height);
			im2col_pkg::REG_KERNEL_WIDTH:  prdata = 32'(cfg_q.kernel_width);
			im2col_pkg::REG_PAD_ROWS:      prdata = 32'(cfg_q.pad_rows);
			im2col_pkg::REG_PAD_COLS:      prdata = 32'(cfg_q.pad_cols);
			im2col_pkg::REG_STRIDE_ROWS:   prdata = 32'(cfg_q.stride_rows);
			im2col_pkg::REG_STRIDE_COLS:   prdata = 32'(cfg_q.stride_cols);
		endcase
	end

endmodule

`default_nettype wire

>>> sv/im2col_out_dim.sv
`default_nettype none

// (size + 2*pad - k) / stride + 1, zero when the kernel exceeds the padded span.
// Free-running three-register chain.
module im2col_out_dim (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [10:0]                   size,
	input  wire logic [3:0]                    pad,
	input  wire logic [4:0]                    ksize,
	input  wire logic [4:0]                    stride,
	output logic [im2col_pkg::DIM_W-1:0]       dim
);

	localparam int DW = im2col_pkg::DIM_W;
	localparam int SH = im2col_pkg::RECIP_SHIFT;
	localparam int PW = DW + im2col_pkg::RECIP_W - 1;

	logic [DW-1:0] span;
	logic [4:0]    keff;
	logic          short_span;
	logic [DW-1:0] diff;

	logic [DW-1:0] diff_a_q;
	logic          short_a_q;
	logic [4:0]    stride_a_q;

	logic [PW-1:0] prod;
	logic [DW-1:0] qe_b_q;
	logic [DW-1:0] diff_b_q;
	logic          short_b_q;
	logic [4:0]    seff_b_q;

	logic [DW+4:0] back;
	logic [DW-1:0] rem;
	logic          fix;
	logic [DW-1:0] dim_q;

	assign span       = DW'(size) + DW'({pad, 1'b0});
	assign keff       = im2col_pkg::at_least_one(ksize);
	assign short_span = span < DW'(keff);
	assign diff       = span - DW'(keff);

	assign prod = PW'(diff_a_q) * PW'(im2col_pkg::recip(stride_a_q));
	assign back = (DW+5)'(qe_b_q) * (DW+5)'(seff_b_q);
	assign rem  = diff_b_q - back[DW-1:0];
	assign fix  = rem >= DW'(seff_b_q);
	assign dim  = dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_a_q   <= '0;
			short_a_q  <= 1'b0;
			stride_a_q <= 5'd1;
			qe_b_q     <= '0;
			diff_b_q   <= '0;
			short_b_q  <= 1'b0;
			seff_b_q   <= 5'd1;
			dim_q      <= DW'(1);
		end else begin
			diff_a_q   <= diff;
			short_a_q  <= short_span;
			stride_a_q <= stride;
			qe_b_q     <= prod[SH+DW-1:SH];
			diff_b_q   <= diff_a_q;
			short_b_q  <= short_a_q;
			seff_b_q   <= im2col_pkg::at_least_one(stride_a_q);
			dim_q      <= short_b_q ? '0 : qe_b_q + DW'(fix) + DW'(1);
		end
	end

endmodule

`default_nettype wire

>>> sv/im2col_cdiv.sv
`default_nettype none

// 16-bit by 5-bit divide through a reciprocal table. The estimate is registered
// here; the one-step correction is combinational and registered by the caller.
module im2col_cdiv (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] dividend,
	input  wire logic [4:0]  divisor,
	output logic [15:0]      quotient,
	output logic [4:0]       remainder
);

	localparam int SH = im2col_pkg::RECIP_SHIFT;
	localparam int PW = 16 + im2col_pkg::RECIP_W - 1;

	logic [PW-1:0] prod;
	logic [15:0]   dividend_s;
	logic [4:0]    div_s;
	logic [15:0]   qe_s;
	logic [20:0]   back;
	logic [15:0]   rem_raw;
	logic          fix;

	assign prod = PW'(dividend) * PW'(im2col_pkg::recip(divisor));

	always_ff @(posedge clk) begin
		if (en) begin
			dividend_s <= dividend;
			div_s      <= im2col_pkg::at_least_one(divisor);
			qe_s       <= prod[SH+15:SH];
		end
	end

	// estimate is low by at most one
	assign back      = 21'(qe_s) * 21'(div_s);
	assign rem_raw   = dividend_s - back[15:0];
	assign fix       = rem_raw >= 16'(div_s);
	assign quotient  = qe_s + 16'(fix);
	assign remainder = fix ? 5'(rem_raw - 16'(div_s)) : rem_raw[4:0];

endmodule

`default_nettype wire

>>> sv/im2col_address_generator_core.sv
`default_nettype none

// im2col address generator. Each transaction names one element of the column
// matrix (column_row, out_y, out_x) and returns the image source address, the
// column-buffer index and the padding flag. Eight register stages, one
// transaction per cycle with no gaps while the result side does not stall. No
// stage has more than one multiplier in series; the kernel divisions use
// reciprocal tables with a one-step correction. A stall on the result side
// holds the whole pipeline. Output dimensions are recomputed from the config
// registers by a chain of registers, which the pipeline depth covers, so a
// transaction may follow a register write in the next cycle.
module im2col_address_generator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [15:0] column_row,
	input  wire logic [10:0] out_y,
	input  wire logic [10:0] out_x,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [27:0]      source_address,
	output logic [37:0]      dest_index,
	output logic             is_padding
);

	localparam int SW = im2col_pkg::SRC_W;
	localparam int DSW = im2col_pkg::DST_W;
	localparam int DW = im2col_pkg::DIM_W;

	im2col_pkg::cfg_t cfg;
	logic [DW-1:0]    rows_out;
	logic [DW-1:0]    cols_out;
	logic             en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// stage payload
	logic [15:0] c_s1, c_s2, c_s3;
	logic [10:0] oy_s1, oy_s2, oy_s3;
	logic [10:0] ox_s1, ox_s2, ox_s3, ox_s4, ox_s5;
	logic [15:0] ys_s1, ys_s2, ys_s3, ys_s4;
	logic [15:0] xs_s1, xs_s2;
	logic [15:0] q1_s2;
	logic [4:0]  kcol_s2;
	logic [10:0] tx_s3, tx_s4, tx_s5, tx_s6, tx_s7;
	logic        inx_s3, inx_s4;
	logic [15:0] ch_s4;
	logic [4:0]  krow_s4;
	logic [SW-1:0] d1_s4;
	logic [10:0] ty_s5;
	logic        in_s5, in_s6, in_s7, in_s8;
	logic [SW-1:0] a_s5, a2_s6, b_s7, src_s8;
	logic [DSW-1:0] d2_s5, dst_s6, dst_s7, dst_s8;

	// combinational
	logic [15:0] q1_a;
	logic [4:0]  kcol_a;
	logic [15:0] ch_b;
	logic [4:0]  krow_b;
	logic [17:0] tx_full;
	logic [17:0] ty_full;
	logic        iny;
	logic [SW-1:0] d1_prod;
	logic [DW+SW-1:0] d2_prod;
	logic [26:0] a_prod;
	logic [SW+10:0] b_prod;

	im2col_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	im2col_out_dim u_rows (
		.clk    (clk),
		.arst_n (arst_n),
		.size   (cfg.image_height),
		.pad    (cfg.pad_rows),
		.ksize  (cfg.kernel_height),
		.stride (cfg.stride_rows),
		.dim    (rows_out)
	);

	im2col_out_dim u_cols (
		.clk    (clk),
		.arst_n (arst_n),
		.size   (cfg.image_width),
		.pad    (cfg.pad_cols),
		.ksize  (cfg.kernel_width),
		.stride (cfg.stride_cols),
		.dim    (cols_out)
	);

	// column_row / kw -> kernel column and remainder row index
	im2col_cdiv u_div_kw (
		.clk       (clk),
		.en        (en),
		.dividend  (column_row),
		.divisor   (cfg.kernel_width),
		.quotient  (q1_a),
		.remainder (kcol_a)
	);

	// (column_row / kw) / kh -> channel and kernel row
	im2col_cdiv u_div_kh (
		.clk       (clk),
		.en        (en),
		.dividend  (q1_s2),
		.divisor   (cfg.kernel_height),
		.quotient  (ch_b),
		.remainder (krow_b)
	);

	assign en           = !v_s8 || result_ready;
	assign item_ready   = en;
	assign result_valid = v_s8;

	// tap positions stay well inside 17 bits, so bit 17 is the sign
	assign tx_full = 18'(xs_s2) + 18'(kcol_s2) - 18'(cfg.pad_cols);
	assign ty_full = 18'(ys_s4) + 18'(krow_s4) - 18'(cfg.pad_rows);
	assign iny     = !ty_full[17] && (ty_full[16:0] < 17'(cfg.image_height));

	assign d1_prod = SW'(c_s3) * SW'(rows_out);
	assign d2_prod = (DW+SW)'(d1_s4) * (DW+SW)'(cols_out);
	assign a_prod  = 27'(ch_s4) * 27'(cfg.image_height);
	assign b_prod  = (SW+11)'(a2_s6) * (SW+11)'(cfg.image_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: window origin, kw divide estimate (in u_div_kw)
			c_s1  <= column_row;
			oy_s1 <= out_y;
			ox_s1 <= out_x;
			ys_s1 <= 16'(out_y) * 16'(im2col_pkg::at_least_one(cfg.stride_rows));
			xs_s1 <= 16'(out_x) * 16'(im2col_pkg::at_least_one(cfg.stride_cols));
			// s2: kernel column
			c_s2    <= c_s1;
			oy_s2   <= oy_s1;
			ox_s2   <= ox_s1;
			ys_s2   <= ys_s1;
			xs_s2   <= xs_s1;
			q1_s2   <= q1_a;
			kcol_s2 <= kcol_a;
			// s3: tap x and its bound
			c_s3   <= c_s2;
			oy_s3  <= oy_s2;
			ox_s3  <= ox_s2;
			ys_s3  <= ys_s2;
			tx_s3  <= tx_full[10:0];
			inx_s3 <= !tx_full[17] && (tx_full[16:0] < 17'(cfg.image_width));
			// s4: channel, kernel row, c * rows_out + oy
			ch_s4   <= ch_b;
			krow_s4 <= krow_b;
			d1_s4   <= d1_prod + SW'(oy_s3);
			ys_s4   <= ys_s3;
			ox_s4   <= ox_s3;
			tx_s4   <= tx_s3;
			inx_s4  <= inx_s3;
			// s5: tap y, ch * H, dest times cols_out
			ty_s5 <= ty_full[10:0];
			in_s5 <= inx_s4 && iny;
			a_s5  <= SW'(a_prod);
			d2_s5 <= d2_prod[DSW-1:0];
			ox_s5 <= ox_s4;
			tx_s5 <= tx_s4;
			// s6
			a2_s6  <= a_s5 + SW'(ty_s5);
			dst_s6 <= d2_s5 + DSW'(ox_s5);
			in_s6  <= in_s5;
			tx_s6  <= tx_s5;
			// s7
			b_s7   <= b_prod[SW-1:0];
			dst_s7 <= dst_s6;
			in_s7  <= in_s6;
			tx_s7  <= tx_s6;
			// s8: output register
			src_s8 <= in_s7 ? b_s7 + SW'(tx_s7) : '0;
			dst_s8 <= dst_s7;
			in_s8  <= in_s7;
		end
	end

	assign source_address = src_s8;
	assign dest_index     = dst_s8;
	assign is_padding     = !in_s8;

`ifndef SYNTHESIS
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && en |=> result_valid)
		else $error("transaction lost between last two stages");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_padding |-> source_address == '0)
		else $error("padding tap with nonzero source address");

	a_kcol_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> kcol_s2 < im2col_pkg::at_least_one(cfg.kernel_width))
		else $error("kernel column not reduced below kernel width");

	a_krow_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> krow_s4 < im2col_pkg::at_least_one(cfg.kernel_height))
		else $error("kernel row not reduced below kernel height");
`endif

endmodule

`default_nettype wire
